FILE: sv/spg_pkg.sv
package spg_pkg;

    // Field and register widths
    localparam int COEF_W       = 48;
    localparam int IDX_W        = 12;
    localparam int REG_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_SIZE     = 4096;
    localparam int IDX_MAX      = MAX_SIZE - 1;

    // Frequency weight arithmetic
    localparam int SQ_W         = 2 * IDX_W;
    localparam int PROD_W       = REG_W + SQ_W;
    localparam int DIV_W        = PROD_W + 2;
    localparam int LAMBDA_ALIGN = 12;

    // Gain: Q1.16, one extra quotient bit for rounding
    localparam int GAIN_FRAC    = 16;
    localparam int Q_W          = GAIN_FRAC + 1;
    localparam int G_W          = GAIN_FRAC + 1;
    localparam int N_CELLS      = Q_W;
    localparam logic [G_W-1:0] GAIN_ONE = G_W'(1) << GAIN_FRAC;

    // Final product, split into two halves of the magnitude
    localparam int HALF_W       = COEF_W / 2;
    localparam int PART_W       = HALF_W + G_W;
    localparam int SUM_W        = COEF_W + G_W;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = CFG_IDX_W'(2);

    localparam logic [REG_W-1:0] LAMBDA_RST  = REG_W'(0);
    localparam logic [REG_W-1:0] X_SCALE_RST = REG_W'(40426);
    localparam logic [REG_W-1:0] Y_SCALE_RST = REG_W'(40426);

    // How the gain is chosen for a word
    typedef enum logic [1:0] {
        FORCE_NONE = 2'd0,
        FORCE_PASS = 2'd1,
        FORCE_ZERO = 2'd2
    } force_t;

    // Side data travelling with the division
    typedef struct packed {
        force_t              force_sel;
        logic                neg;
        logic [COEF_W-1:0]   mag;
    } side_t;

    typedef struct packed {
        logic [DIV_W-1:0]    r;
        logic [DIV_W-1:0]    d;
        logic [Q_W-1:0]      q;
        side_t               side;
    } div_word_t;

endpackage

FILE: sv/spg_if.sv
// Coefficient input channel
interface spg_in_if import spg_pkg::*;;
    logic                valid;
    logic                ready;
    logic [COEF_W-1:0]   coefficient;
    logic [IDX_W-1:0]    col_index;
    logic [IDX_W-1:0]    row_index;

    modport source (output valid, coefficient, col_index, row_index, input ready);
    modport sink   (input valid, coefficient, col_index, row_index, output ready);
endinterface

// Filtered coefficient output channel
interface spg_out_if import spg_pkg::*;;
    logic                valid;
    logic                ready;
    logic [COEF_W-1:0]   filtered_coefficient;

    modport source (output valid, filtered_coefficient, input ready);
    modport sink   (input valid, filtered_coefficient, output ready);
endinterface

// Register write channel
interface spg_cfg_if import spg_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [REG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/spg_weight.sv
// Front end: index squares, scaled weights, divisor set-up (three stages)
module spg_weight import spg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  logic [COEF_W-1:0]  coefficient,
    input  logic [IDX_W-1:0]   col_index,
    input  logic [IDX_W-1:0]   row_index,
    input  logic [REG_W-1:0]   lambda,
    input  logic [REG_W-1:0]   x_scale,
    input  logic [REG_W-1:0]   y_scale,
    output logic               dn_valid,
    input  logic               dn_ready,
    output div_word_t          dn_word
);

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic              s1_ready, s2_ready;
    logic [SQ_W-1:0]   s1_col2_reg, s1_row2_reg, s1_col2_next, s1_row2_next;
    side_t             s1_side_reg, s1_side_next;
    logic [PROD_W-1:0] s2_px_reg, s2_py_reg, s2_px_next, s2_py_next;
    side_t             s2_side_reg;
    div_word_t         s3_word_reg, s3_word_next;
    logic [IDX_W-1:0]  col_c, row_c;
    logic [DIV_W-1:0]  c_sum;

    // Ready ripples back; a stage takes a word when empty or draining
    assign s2_ready = !s3_valid_reg || dn_ready;
    assign s1_ready = !s2_valid_reg || s2_ready;
    assign up_ready = !s1_valid_reg || s1_ready;

    // Stage 1: clamp, square, sign split, special cases
    always_comb
    begin
        col_c = (32'(col_index) > IDX_MAX) ? IDX_W'(IDX_MAX) : col_index;
        row_c = (32'(row_index) > IDX_MAX) ? IDX_W'(IDX_MAX) : row_index;
        s1_col2_next = SQ_W'(col_c) * SQ_W'(col_c);
        s1_row2_next = SQ_W'(row_c) * SQ_W'(row_c);
        s1_side_next.neg = coefficient[COEF_W-1];
        s1_side_next.mag = coefficient[COEF_W-1] ? (~coefficient + COEF_W'(1))
                                                 : coefficient;
        if (lambda == '0)
            s1_side_next.force_sel = FORCE_PASS;
        else if (col_c == '0 && row_c == '0)
            s1_side_next.force_sel = FORCE_ZERO;
        else
            s1_side_next.force_sel = FORCE_NONE;
    end

    // Stage 2: scale by the per-axis factors
    assign s2_px_next = PROD_W'(x_scale) * PROD_W'(s1_col2_reg);
    assign s2_py_next = PROD_W'(y_scale) * PROD_W'(s1_row2_reg);

    // Stage 3: weight c and divisor d = c + lambda aligned to Q.28
    always_comb
    begin
        c_sum = DIV_W'(s2_px_reg) + DIV_W'(s2_py_reg);
        s3_word_next.r    = c_sum;
        s3_word_next.d    = c_sum + (DIV_W'(lambda) << LAMBDA_ALIGN);
        s3_word_next.q    = '0;
        s3_word_next.side = s2_side_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready) s1_valid_reg <= up_valid;
            if (s1_ready) s2_valid_reg <= s1_valid_reg;
            if (s2_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            s1_col2_reg <= s1_col2_next;
            s1_row2_reg <= s1_row2_next;
            s1_side_reg <= s1_side_next;
        end
        if (s1_valid_reg && s1_ready)
        begin
            s2_px_reg   <= s2_px_next;
            s2_py_reg   <= s2_py_next;
            s2_side_reg <= s1_side_reg;
        end
        if (s2_valid_reg && s2_ready)
            s3_word_reg <= s3_word_next;
    end

    assign dn_valid = s3_valid_reg;
    assign dn_word  = s3_word_reg;

endmodule

FILE: sv/spg_div_cell.sv
// One restoring division step: shift remainder, trial subtract, quotient bit
module spg_div_cell import spg_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  div_word_t  up_word,
    output logic       dn_valid,
    input  logic       dn_ready,
    output div_word_t  dn_word
);

    logic             valid_reg;
    div_word_t        word_reg, word_next;
    logic [DIV_W:0]   r2, d_ext, r_new;
    logic             fits;

    assign up_ready = !valid_reg || dn_ready;

    // Trial subtract
    always_comb
    begin
        r2    = {up_word.r, 1'b0};
        d_ext = {1'b0, up_word.d};
        fits  = (r2 >= d_ext);
        r_new = fits ? (r2 - d_ext) : r2;
        word_next.r    = r_new[DIV_W-1:0];
        word_next.d    = up_word.d;
        word_next.q    = {up_word.q[Q_W-2:0], fits};
        word_next.side = up_word.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    // Remainder stays below the divisor on a real division
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && word_reg.side.force_sel == FORCE_NONE |-> word_reg.r < word_reg.d)
        else $error("division remainder reached divisor");

    // A blocked cell keeps its word
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(word_reg))
        else $error("division cell lost a stalled word");

endmodule

FILE: sv/spg_scale.sv
// Back end: gain rounding, split product, rounding and sign restore
module spg_scale import spg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  div_word_t          up_word,
    output logic               dn_valid,
    input  logic               dn_ready,
    output logic [COEF_W-1:0]  dn_result
);

    logic               g_valid_reg, p_valid_reg, o_valid_reg;
    logic               g_ready, p_ready;
    logic [G_W-1:0]     g_reg, g_next;
    logic [Q_W:0]       q_inc;
    logic               g_neg_reg, p_neg_reg;
    logic [COEF_W-1:0]  g_mag_reg;
    logic [PART_W-1:0]  p_lo_reg, p_hi_reg, p_lo_next, p_hi_next;
    logic [SUM_W-1:0]   sum;
    logic [COEF_W-1:0]  rmag, o_res_reg, o_res_next;

    assign p_ready  = !o_valid_reg || dn_ready;
    assign g_ready  = !p_valid_reg || p_ready;
    assign up_ready = !g_valid_reg || g_ready;

    // Gain: quotient rounded half up, or forced
    always_comb
    begin
        q_inc = {1'b0, up_word.q} + (Q_W+1)'(1);
        case (up_word.side.force_sel)
            FORCE_PASS: g_next = GAIN_ONE;
            FORCE_ZERO: g_next = '0;
            default:    g_next = q_inc[G_W:1];
        endcase
    end

    // Two half-width partial products
    assign p_lo_next = PART_W'(g_mag_reg[HALF_W-1:0]) * PART_W'(g_reg);
    assign p_hi_next = PART_W'(g_mag_reg[COEF_W-1:HALF_W]) * PART_W'(g_reg);

    // Recombine, round to nearest, reapply sign
    always_comb
    begin
        sum = (SUM_W'(p_hi_reg) << HALF_W) + SUM_W'(p_lo_reg)
            + (SUM_W'(1) << (GAIN_FRAC - 1));
        rmag = sum[GAIN_FRAC +: COEF_W];
        o_res_next = p_neg_reg ? (~rmag + COEF_W'(1)) : rmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready) g_valid_reg <= up_valid;
            if (g_ready)  p_valid_reg <= g_valid_reg;
            if (p_ready)  o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            g_reg     <= g_next;
            g_neg_reg <= up_word.side.neg;
            g_mag_reg <= up_word.side.mag;
        end
        if (g_valid_reg && g_ready)
        begin
            p_lo_reg  <= p_lo_next;
            p_hi_reg  <= p_hi_next;
            p_neg_reg <= g_neg_reg;
        end
        if (p_valid_reg && p_ready)
            o_res_reg <= o_res_next;
    end

    assign dn_valid  = o_valid_reg;
    assign dn_result = o_res_reg;

    // Gain never exceeds unity, so the result cannot grow
    a_gain_unity: assert property (@(posedge clk) disable iff (!rst_n)
        g_valid_reg |-> g_reg <= GAIN_ONE)
        else $error("gain above unity");

endmodule

FILE: sv/screened_poisson_dct_gain.sv
// Channel    Dir  Word contents
// coef       in   coefficient (48 s), col_index (12 u), row_index (12 u)
// filtered   out  filtered_coefficient (48 s)
// cfg        in   index (0 lambda, 1 x_scale, 2 y_scale), data (32 u)
//
// One word per cycle sustained while the output is not stalled; the path is 3 front stages, a chain of
// 17 restoring division cells (one quotient bit each), 3 back stages.
// Reset clears every stage valid and loads the registers with their reset values.
// Each stage holds its word under back-pressure; empty stages fill, so input is
// taken while a result waits. cfg is always ready and a write updates its register at the next clock edge.
module screened_poisson_dct_gain import spg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    spg_in_if.sink    coef,
    spg_out_if.source filtered,
    spg_cfg_if.sink   cfg
);

    logic [REG_W-1:0] lambda_reg, x_scale_reg, y_scale_reg;
    logic [N_CELLS:0] link_valid, link_ready;
    div_word_t        link_word [N_CELLS+1];

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg  <= LAMBDA_RST;
            x_scale_reg <= X_SCALE_RST;
            y_scale_reg <= Y_SCALE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LAMBDA:  lambda_reg  <= cfg.data;
                REG_X_SCALE: x_scale_reg <= cfg.data;
                REG_Y_SCALE: y_scale_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    // Front end
    spg_weight u_weight (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (coef.valid),
        .up_ready    (coef.ready),
        .coefficient (coef.coefficient),
        .col_index   (coef.col_index),
        .row_index   (coef.row_index),
        .lambda      (lambda_reg),
        .x_scale     (x_scale_reg),
        .y_scale     (y_scale_reg),
        .dn_valid    (link_valid[0]),
        .dn_ready    (link_ready[0]),
        .dn_word     (link_word[0])
    );

    // Division chain
    for (genvar k = 0; k < N_CELLS; k++)
    begin : g_cell
        spg_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_word  (link_word[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_word  (link_word[k+1])
        );
    end

    // Back end and output register
    spg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (link_valid[N_CELLS]),
        .up_ready  (link_ready[N_CELLS]),
        .up_word   (link_word[N_CELLS]),
        .dn_valid  (filtered.valid),
        .dn_ready  (filtered.ready),
        .dn_result (filtered.filtered_coefficient)
    );

endmodule
